// File: sv/fw2_pkg.sv
// fw2_pkg: shared constants, codes and state type of the 2-d fenwick range-sum block
// no dependencies; compiled first
`timescale 1ns / 1ps

package fw2_pkg;

	// physical size of the tree store
	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 64;
	localparam int DEPTH     = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int ROW_W     = $clog2(MAX_ROWS + 1);
	localparam int COL_W     = $clog2(MAX_COLS + 1);

	// fixed field widths
	localparam int COORD_W   = 7;
	localparam int SIZE_W    = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int SUM_W     = 64;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// File: sv/fw2_if.sv
// fw2_if: valid/ready channels for request items and result items
// depends on fw2_pkg
`timescale 1ns / 1ps

interface fw2_req_if;
	import fw2_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [COORD_W-1:0]        row_a;
	logic [COORD_W-1:0]        col_a;
	logic [COORD_W-1:0]        row_b;
	logic [COORD_W-1:0]        col_b;
	logic signed [SUM_W-1:0]   delta;

	modport source (output valid, opcode, row_a, col_a, row_b, col_b, delta, input ready);
	modport sink   (input valid, opcode, row_a, col_a, row_b, col_b, delta, output ready);
endinterface

interface fw2_rsp_if;
	import fw2_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SUM_W-1:0]   range_sum;
	logic                      bad_coordinate;

	modport source (output valid, range_sum, bad_coordinate, input ready);
	modport sink   (input valid, range_sum, bad_coordinate, output ready);
endinterface

// File: sv/fw2_ram.sv
// fw2_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module fw2_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/fenwick_2d_range_sum.sv
// fenwick_2d_range_sum: 2-d binary indexed tree, point update and rectangle sum
// one item at a time; while walking, one tree cell read (and on update written back) per cycle,
//   apart from the steps in which a query loads its next prefix corner
// an update walks the cells on its upward path (at most 7 x 7); a query walks four prefix paths
// bad or empty items skip the walk; the block takes the next item once each result is loaded
// after reset a clearing pass zeroes all MAX_ROWS*MAX_COLS cells of the store; no item meanwhile
`timescale 1ns / 1ps

module fenwick_2d_range_sum (
	input  logic                          clk,
	input  logic                          arst_n,
	fw2_req_if.sink                       req,
	fw2_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [fw2_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fw2_pkg::CFG_W-1:0]     cfg_data
);
	import fw2_pkg::*;

	localparam logic [1:0] PFX_LAST = 2'b11;

	state_t                  state_q, state_d;
	logic [SIZE_W-1:0]       rows_q, cols_q;
	logic [ADDR_W-1:0]       clr_q;

	op_t                     op_q;
	logic [SUM_W-1:0]        delta_q;
	logic                    bad_q;
	logic [ROW_W-1:0]        r_hi_q, r_lo_q;
	logic [COL_W-1:0]        c_hi_q, c_lo_q;
	logic [ROW_W-1:0]        x_q, x_d;
	logic [COL_W-1:0]        y_q, y_d;
	logic [1:0]              pfx_q, pfx_d;
	logic [SUM_W-1:0]        acc_q;

	logic                    valid_s1, neg_s1;
	logic [ADDR_W-1:0]       addr_s1;

	logic                    rsp_valid_q, bad_rsp_q;
	logic [SUM_W-1:0]        sum_rsp_q;

	logic                    accept, issue, start_bad, load_rsp;
	op_t                     req_op;
	logic [ROW_W-1:0]        x_low;
	logic [COL_W-1:0]        y_low;
	logic [ROW_W:0]          x_up;
	logic [COL_W:0]          y_up;
	logic [ROW_W-1:0]        x_down;
	logic [COL_W-1:0]        y_down;
	logic [ADDR_W-1:0]       rd_addr;
	logic [SUM_W-1:0]        rd_data;
	logic [SUM_W-1:0]        add_a, add_b, add_sum;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [SUM_W-1:0]        ram_wdata;

	function automatic logic coord_ok(logic [COORD_W-1:0] v, logic [SIZE_W-1:0] size, int cap);
		return (v != '0) && (v <= size) && (int'(v) <= cap);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SIZE_W'(64);
			cols_q <= SIZE_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request decode: coordinate checks and empty rectangle
	assign req_op = op_t'(req.opcode);
	assign accept = req.valid && req.ready;

	always_comb begin
		if (req_op == OP_UPDATE) begin
			start_bad = !(coord_ok(req.row_a, rows_q, MAX_ROWS) &&
				coord_ok(req.col_a, cols_q, MAX_COLS));
		end else begin
			start_bad = !(coord_ok(req.row_a, rows_q, MAX_ROWS) &&
				coord_ok(req.row_b, rows_q, MAX_ROWS) &&
				coord_ok(req.col_a, cols_q, MAX_COLS) &&
				coord_ok(req.col_b, cols_q, MAX_COLS));
		end
	end

	// lowest-set-bit steps of the walk
	assign x_low  = x_q & (~x_q + 1'b1);
	assign y_low  = y_q & (~y_q + 1'b1);
	assign x_up   = {1'b0, x_q} + {1'b0, x_low};
	assign y_up   = {1'b0, y_q} + {1'b0, y_low};
	assign x_down = x_q & (x_q - 1'b1);
	assign y_down = y_q & (y_q - 1'b1);
	assign rd_addr = ADDR_W'(ADDR_W'(x_q - 1'b1) * ADDR_W'(MAX_COLS)) + ADDR_W'(y_q - 1'b1);

	// sequencer: next state and walk control
	always_comb begin
		state_d  = state_q;
		x_d      = x_q;
		y_d      = y_q;
		pfx_d    = pfx_q;
		issue    = 1'b0;
		load_rsp = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req_op == OP_UPDATE) begin
						x_d = ROW_W'(req.row_a);
						y_d = COL_W'(req.col_a);
					end else begin
						x_d = ROW_W'(req.row_b);
						y_d = COL_W'(req.col_b);
					end
					pfx_d = '0;
					if (start_bad || (req_op == OP_QUERY &&
						(req.row_a > req.row_b || req.col_a > req.col_b))) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (op_q == OP_UPDATE) begin
					// walk upward to the physical edge of the store
					issue = 1'b1;
					if (y_up > (COL_W+1)'(MAX_COLS)) begin
						y_d = c_hi_q;
						x_d = x_up[ROW_W-1:0];
						if (x_up > (ROW_W+1)'(MAX_ROWS)) begin
							state_d = ST_DRAIN;
						end
					end else begin
						y_d = y_up[COL_W-1:0];
					end
				end else if (x_q == '0 || y_q == '0) begin
					// current prefix finished or empty: load the next corner
					if (pfx_q == PFX_LAST) begin
						state_d = ST_DRAIN;
					end else begin
						pfx_d = pfx_q + 1'b1;
						x_d   = pfx_d[0] ? r_lo_q : r_hi_q;
						y_d   = pfx_d[1] ? c_lo_q : c_hi_q;
					end
				end else begin
					issue = 1'b1;
					if (y_down == '0) begin
						x_d = x_down;
						y_d = pfx_q[1] ? c_lo_q : c_hi_q;
					end else begin
						y_d = y_down;
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// item registers and walk position
	always_ff @(posedge clk) begin
		x_q     <= x_d;
		y_q     <= y_d;
		pfx_q   <= pfx_d;
		addr_s1 <= rd_addr;
		neg_s1  <= (op_q == OP_QUERY) && (pfx_q[0] ^ pfx_q[1]);
		if (accept) begin
			op_q    <= req_op;
			delta_q <= req.delta;
			bad_q   <= start_bad;
			acc_q   <= '0;
			r_hi_q  <= ROW_W'(req.row_b);
			r_lo_q  <= ROW_W'(req.row_a - 1'b1);
			c_lo_q  <= COL_W'(req.col_a - 1'b1);
			c_hi_q  <= (req_op == OP_UPDATE) ? COL_W'(req.col_a) : COL_W'(req.col_b);
		end else if (valid_s1 && op_q == OP_QUERY) begin
			acc_q <= add_sum;
		end
	end

	// shared adder: cell + delta on update, acc +/- cell on query
	assign add_a   = (op_q == OP_UPDATE) ? delta_q : acc_q;
	assign add_b   = neg_s1 ? ~rd_data : rd_data;
	assign add_sum = add_a + add_b + SUM_W'(neg_s1);

	// store write port: clearing pass or update write-back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = valid_s1 && (op_q == OP_UPDATE);
			ram_waddr = addr_s1;
			ram_wdata = add_sum;
		end
	end

	fw2_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			bad_rsp_q <= bad_q;
			sum_rsp_q <= (op_q == OP_QUERY && !bad_q) ? acc_q : '0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.range_sum      = sum_rsp_q;
	assign rsp.bad_coordinate = bad_rsp_q;

	// checks
	a_write_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != ST_CLEAR) |-> (op_q == OP_UPDATE))
		else $error("store written outside clearing pass by a query item");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !valid_s1)
		else $error("cell access still in flight when a new item may be taken");

	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.bad_coordinate) |-> (rsp.range_sum == '0))
		else $error("flagged item carries a non-zero sum");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item taken before the first finished");

endmodule
